// File: rtl/cpec_pkg.sv
`timescale 1ns / 1ps
package cpec_pkg;

  localparam int unsigned SQRT_STEPS = 25;
  localparam int unsigned MASS_STEPS = 24;
  localparam int unsigned DIV_STEPS  = 24;

  // pipeline register indices
  localparam int unsigned ST_A       = 0;
  localparam int unsigned ST_B       = 1;
  localparam int unsigned ST_C       = 2;
  localparam int unsigned ST_SQ0     = 3;
  localparam int unsigned ST_LD      = ST_SQ0 + SQRT_STEPS;
  localparam int unsigned ST_DV0     = ST_LD + 1;
  localparam int unsigned ST_NRM     = ST_DV0 + DIV_STEPS;
  localparam int unsigned ST_M1      = ST_NRM + 1;
  localparam int unsigned ST_M2      = ST_M1 + 1;
  localparam int unsigned ST_M3      = ST_M2 + 1;
  localparam int unsigned ST_M4      = ST_M3 + 1;
  localparam int unsigned ST_M5      = ST_M4 + 1;
  localparam int unsigned ST_OUT     = ST_M5 + 1;
  localparam int unsigned NUM_STAGES = ST_OUT + 1;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [24:0] NORM_ONE = 25'h1000000;

  typedef enum logic [1:0] {
    CS_NONE     = 2'd0,
    CS_SAME     = 2'd1,
    CS_SEPARATE = 2'd2,
    CS_RESOLVED = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    status_e            status;
    logic [24:0]        rsum;
    logic signed [25:0] dx;
    logic signed [25:0] dy;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic [32:0]        msum;
    logic [32:0]        rem1;
    logic [32:0]        rem2;
    logic [23:0]        q1;
    logic [23:0]        q2;
    logic [49:0]        dx2;
    logic [49:0]        dy2;
    logic [49:0]        rsq;
    logic [49:0]        rad;
    logic [26:0]        srem;
    logic [24:0]        root;
    logic [23:0]        ov;
    logic [24:0]        nrx;
    logic [24:0]        nry;
    logic [24:0]        qx;
    logic [24:0]        qy;
    logic signed [25:0] nx;
    logic signed [25:0] ny;
    logic signed [58:0] pdx;
    logic signed [58:0] pdy;
    logic signed [50:0] cx;
    logic signed [50:0] cy;
    logic [33:0]        s;
    logic [34:0]        t;
    logic [34:0]        j1;
    logic [34:0]        j2;
    logic signed [61:0] ax;
    logic signed [61:0] ay;
    logic signed [61:0] bx;
    logic signed [61:0] by;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sh007FFFFFFF;
    lo = -40'sh0080000000;
    if (x > hi) begin
      return 32'sh7FFFFFFF;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// File: rtl/circle_pair_elastic_collision_core.sv
`timescale 1ns / 1ps
// Throughput: one pair per cycle unless m_axis_tready stalls the pipe; the square root (25 stages) and the normal
// divider (25 stages) resolve one result bit per stage, as do the mass-ratio dividers.
// A one-entry input skid register keeps s_axis_tready registered; the pipe stalls as one.
// Reset (rst_ni low, asynchronous) empties the pipe and skid and sets restitution to 1.0.
module circle_pair_elastic_collision_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [16:0]  cfg_wdata_i,    // restitution, Q1.16
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // p1x, p1y, v1x, v1y, r1(24), m1, p2x, p2y, v2x, v2y, r2(24), m2
  input  logic [367:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y
  output logic [255:0] m_axis_tdata,
  // contact_status
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned NS = cpec_pkg::NUM_STAGES;

  logic [16:0]     restitution_q;
  logic            skid_v_q;
  logic [367:0]    skid_q;
  logic [NS-1:0]   vld_q;
  cpec_pkg::item_t pipe_q [NS];
  cpec_pkg::item_t nxt    [NS];
  logic            adv;
  logic            in_v;
  logic [367:0]    in_data;
  logic [17:0]     fact;

  assign adv           = !vld_q[NS-1] || m_axis_tready;
  assign s_axis_tready = !skid_v_q;
  assign in_v          = skid_v_q || s_axis_tvalid;
  assign in_data       = skid_v_q ? skid_q : s_axis_tdata;
  assign fact          = {1'b0, cpec_pkg::ONE_Q16} + {1'b0, restitution_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= cpec_pkg::ONE_Q16;
    end else if (cfg_we_i) begin
      restitution_q <= (cfg_wdata_i > cpec_pkg::ONE_Q16) ? cpec_pkg::ONE_Q16 : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (adv) begin
        skid_v_q <= 1'b0;
        vld_q    <= {vld_q[NS-2:0], in_v};
      end else if (s_axis_tvalid && s_axis_tready) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && s_axis_tvalid && s_axis_tready) begin
      skid_q <= s_axis_tdata;
    end
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        pipe_q[k] <= nxt[k];
      end
    end
  end

  // centres, coarse overlap test, mass sum
  always_comb begin
    cpec_pkg::item_t it;
    logic [23:0] r1, r2;
    logic [31:0] m1, m2;
    logic [33:0] c1x, c1y, c2x, c2y, dx34, dy34, adx, ady;
    logic        far;
    it        = '0;
    it.p1x    = in_data[31:0];
    it.p1y    = in_data[63:32];
    it.v1x    = in_data[95:64];
    it.v1y    = in_data[127:96];
    r1        = in_data[151:128];
    m1        = in_data[183:152];
    it.p2x    = in_data[215:184];
    it.p2y    = in_data[247:216];
    it.v2x    = in_data[279:248];
    it.v2y    = in_data[311:280];
    r2        = in_data[335:312];
    m2        = in_data[367:336];
    c1x       = {{2{it.p1x[31]}}, it.p1x} + {10'd0, r1};
    c1y       = {{2{it.p1y[31]}}, it.p1y} + {10'd0, r1};
    c2x       = {{2{it.p2x[31]}}, it.p2x} + {10'd0, r2};
    c2y       = {{2{it.p2y[31]}}, it.p2y} + {10'd0, r2};
    dx34      = c2x - c1x;
    dy34      = c2y - c1y;
    adx       = dx34[33] ? (34'd0 - dx34) : dx34;
    ady       = dy34[33] ? (34'd0 - dy34) : dy34;
    it.rsum   = {1'b0, r1} + {1'b0, r2};
    far       = (adx >= {9'd0, it.rsum}) || (ady >= {9'd0, it.rsum});
    it.status = far ? cpec_pkg::CS_NONE : cpec_pkg::CS_RESOLVED;
    it.dx     = dx34[25:0];
    it.dy     = dy34[25:0];
    it.dvx    = {it.v1x[31], it.v1x} - {it.v2x[31], it.v2x};
    it.dvy    = {it.v1y[31], it.v1y} - {it.v2y[31], it.v2y};
    if (m1 == 32'd0) m1 = 32'd1;
    if (m2 == 32'd0) m2 = 32'd1;
    it.msum   = {1'b0, m1} + {1'b0, m2};
    it.rem1   = {1'b0, m1};
    it.rem2   = {1'b0, m2};
    nxt[cpec_pkg::ST_A] = it;
  end

  // squares
  always_comb begin
    cpec_pkg::item_t it;
    logic signed [51:0] sqx, sqy;
    it     = pipe_q[cpec_pkg::ST_A];
    sqx    = it.dx * it.dx;
    sqy    = it.dy * it.dy;
    it.dx2 = sqx[49:0];
    it.dy2 = sqy[49:0];
    it.rsq = it.rsum * it.rsum;
    nxt[cpec_pkg::ST_B] = it;
  end

  // exact overlap test
  always_comb begin
    cpec_pkg::item_t it;
    logic [50:0] d2;
    it = pipe_q[cpec_pkg::ST_B];
    d2 = {1'b0, it.dx2} + {1'b0, it.dy2};
    if (it.status == cpec_pkg::CS_RESOLVED) begin
      if (d2 >= {1'b0, it.rsq}) begin
        it.status = cpec_pkg::CS_NONE;
      end else if (d2 == 51'd0) begin
        it.status = cpec_pkg::CS_SAME;
      end
    end
    it.rad  = d2[49:0];
    it.srem = '0;
    it.root = '0;
    nxt[cpec_pkg::ST_C] = it;
  end

  // square root, one bit a stage; mass ratios alongside
  for (genvar i = 0; i < cpec_pkg::SQRT_STEPS; i++) begin : g_sqrt
    always_comb begin
      cpec_pkg::item_t it;
      logic [27:0] r4, trial, rdiff;
      logic [33:0] m1s, m2s;
      it    = pipe_q[cpec_pkg::ST_SQ0 + i - 1];
      r4    = {it.srem[25:0], it.rad[49:48]};
      trial = {1'b0, it.root, 2'b01};
      rdiff = r4 - trial;
      if (r4 >= trial) begin
        it.srem = rdiff[26:0];
        it.root = {it.root[23:0], 1'b1};
      end else begin
        it.srem = r4[26:0];
        it.root = {it.root[23:0], 1'b0};
      end
      it.rad = {it.rad[47:0], 2'b00};
      m1s    = {it.rem1, 1'b0};
      m2s    = {it.rem2, 1'b0};
      if (i < cpec_pkg::MASS_STEPS) begin
        if (m1s >= {1'b0, it.msum}) begin
          m1s   = m1s - {1'b0, it.msum};
          it.q1 = {it.q1[22:0], 1'b1};
        end else begin
          it.q1 = {it.q1[22:0], 1'b0};
        end
        if (m2s >= {1'b0, it.msum}) begin
          m2s   = m2s - {1'b0, it.msum};
          it.q2 = {it.q2[22:0], 1'b1};
        end else begin
          it.q2 = {it.q2[22:0], 1'b0};
        end
        it.rem1 = m1s[32:0];
        it.rem2 = m2s[32:0];
      end
      nxt[cpec_pkg::ST_SQ0 + i] = it;
    end
  end

  // integer bit of the normal, half overlap
  always_comb begin
    cpec_pkg::item_t it;
    logic [25:0] adx, ady, dd;
    logic [24:0] gap;
    it  = pipe_q[cpec_pkg::ST_LD - 1];
    gap = it.rsum - it.root;
    it.ov = gap[24:1];
    adx = it.dx[25] ? (26'd0 - it.dx) : it.dx;
    ady = it.dy[25] ? (26'd0 - it.dy) : it.dy;
    dd  = {1'b0, it.root};
    if (adx >= dd) begin
      adx   = adx - dd;
      it.qx = 25'd1;
    end else begin
      it.qx = 25'd0;
    end
    if (ady >= dd) begin
      ady   = ady - dd;
      it.qy = 25'd1;
    end else begin
      it.qy = 25'd0;
    end
    it.nrx = adx[24:0];
    it.nry = ady[24:0];
    nxt[cpec_pkg::ST_LD] = it;
  end

  // fractional bits of the normal
  for (genvar i = 0; i < cpec_pkg::DIV_STEPS; i++) begin : g_div
    always_comb begin
      cpec_pkg::item_t it;
      logic [25:0] rx, ry, dd;
      it = pipe_q[cpec_pkg::ST_DV0 + i - 1];
      dd = {1'b0, it.root};
      rx = {it.nrx, 1'b0};
      ry = {it.nry, 1'b0};
      if (rx >= dd) begin
        rx    = rx - dd;
        it.qx = {it.qx[23:0], 1'b1};
      end else begin
        it.qx = {it.qx[23:0], 1'b0};
      end
      if (ry >= dd) begin
        ry    = ry - dd;
        it.qy = {it.qy[23:0], 1'b1};
      end else begin
        it.qy = {it.qy[23:0], 1'b0};
      end
      it.nrx = rx[24:0];
      it.nry = ry[24:0];
      nxt[cpec_pkg::ST_DV0 + i] = it;
    end
  end

  // signed normal, truncated toward zero
  always_comb begin
    cpec_pkg::item_t it;
    it    = pipe_q[cpec_pkg::ST_NRM - 1];
    it.nx = it.dx[25] ? -$signed({1'b0, it.qx}) : $signed({1'b0, it.qx});
    it.ny = it.dy[25] ? -$signed({1'b0, it.qy}) : $signed({1'b0, it.qy});
    nxt[cpec_pkg::ST_NRM] = it;
  end

  always_comb begin
    cpec_pkg::item_t it;
    it     = pipe_q[cpec_pkg::ST_M1 - 1];
    it.pdx = it.dvx * it.nx;
    it.pdy = it.dvy * it.ny;
    it.cx  = $signed({1'b0, it.ov}) * it.nx;
    it.cy  = $signed({1'b0, it.ov}) * it.ny;
    nxt[cpec_pkg::ST_M1] = it;
  end

  // closing speed
  always_comb begin
    cpec_pkg::item_t it;
    logic signed [59:0] dot;
    it  = pipe_q[cpec_pkg::ST_M2 - 1];
    dot = {it.pdx[58], it.pdx} + {it.pdy[58], it.pdy};
    if (it.status == cpec_pkg::CS_RESOLVED && dot[59]) begin
      it.status = cpec_pkg::CS_SEPARATE;
    end
    it.s = dot[57:24];
    nxt[cpec_pkg::ST_M2] = it;
  end

  always_comb begin
    cpec_pkg::item_t it;
    logic [51:0] st;
    it   = pipe_q[cpec_pkg::ST_M3 - 1];
    st   = it.s * fact;
    it.t = st[50:16];
    nxt[cpec_pkg::ST_M3] = it;
  end

  // impulse shares, inverse to mass
  always_comb begin
    cpec_pkg::item_t it;
    logic [58:0] pj1, pj2;
    it    = pipe_q[cpec_pkg::ST_M4 - 1];
    pj1   = it.t * it.q2;
    pj2   = it.t * it.q1;
    it.j1 = pj1[58:24];
    it.j2 = pj2[58:24];
    nxt[cpec_pkg::ST_M4] = it;
  end

  always_comb begin
    cpec_pkg::item_t it;
    it    = pipe_q[cpec_pkg::ST_M5 - 1];
    it.ax = $signed({1'b0, it.j1}) * it.nx;
    it.ay = $signed({1'b0, it.j1}) * it.ny;
    it.bx = $signed({1'b0, it.j2}) * it.nx;
    it.by = $signed({1'b0, it.j2}) * it.ny;
    nxt[cpec_pkg::ST_M5] = it;
  end

  // apply and saturate; anything not resolved passes through
  always_comb begin
    cpec_pkg::item_t it;
    logic signed [39:0] eax, eay, ebx, eby, ecx, ecy;
    it  = pipe_q[cpec_pkg::ST_OUT - 1];
    eax = {{2{it.ax[61]}}, it.ax[61:24]};
    eay = {{2{it.ay[61]}}, it.ay[61:24]};
    ebx = {{2{it.bx[61]}}, it.bx[61:24]};
    eby = {{2{it.by[61]}}, it.by[61:24]};
    ecx = {{13{it.cx[50]}}, it.cx[50:24]};
    ecy = {{13{it.cy[50]}}, it.cy[50:24]};
    if (it.status == cpec_pkg::CS_RESOLVED) begin
      it.v1x = cpec_pkg::sat32({{8{it.v1x[31]}}, it.v1x} - eax);
      it.v1y = cpec_pkg::sat32({{8{it.v1y[31]}}, it.v1y} - eay);
      it.v2x = cpec_pkg::sat32({{8{it.v2x[31]}}, it.v2x} + ebx);
      it.v2y = cpec_pkg::sat32({{8{it.v2y[31]}}, it.v2y} + eby);
      it.p1x = cpec_pkg::sat32({{8{it.p1x[31]}}, it.p1x} - ecx);
      it.p1y = cpec_pkg::sat32({{8{it.p1y[31]}}, it.p1y} - ecy);
      it.p2x = cpec_pkg::sat32({{8{it.p2x[31]}}, it.p2x} + ecx);
      it.p2y = cpec_pkg::sat32({{8{it.p2y[31]}}, it.p2y} + ecy);
    end
    nxt[cpec_pkg::ST_OUT] = it;
  end

  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = {pipe_q[NS-1].v2y, pipe_q[NS-1].v2x,
                          pipe_q[NS-1].p2y, pipe_q[NS-1].p2x,
                          pipe_q[NS-1].v1y, pipe_q[NS-1].v1x,
                          pipe_q[NS-1].p1y, pipe_q[NS-1].p1x};
  assign m_axis_tuser  = pipe_q[NS-1].status;

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
    else $error("pipe moved while output stalled");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !adv |=> skid_v_q && $stable(skid_q))
    else $error("skid entry lost or changed");

  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[cpec_pkg::ST_NRM-1] &&
    pipe_q[cpec_pkg::ST_NRM-1].status == cpec_pkg::CS_RESOLVED
    |-> pipe_q[cpec_pkg::ST_NRM-1].qx <= cpec_pkg::NORM_ONE &&
        pipe_q[cpec_pkg::ST_NRM-1].qy <= cpec_pkg::NORM_ONE)
    else $error("normal component above one");

  a_rest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restitution_q <= cpec_pkg::ONE_Q16)
    else $error("restitution above one");
`endif

endmodule
